>>> src/assert_macros.svh
// Assertion helpers used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that A implies C in the same cycle.
`define CKCL_ASSERT_IMP(NAME, CLK, RST, A, C) \
   NAME: assert property (@(posedge CLK) disable iff (RST) (A) |-> (C)) \
      else $error("assertion failed");

// Check that A implies C in the next cycle.
`define CKCL_ASSERT_NEXT(NAME, CLK, RST, A, C) \
   NAME: assert property (@(posedge CLK) disable iff (RST) (A) |=> (C)) \
      else $error("assertion failed");

`else

`define CKCL_ASSERT_IMP(NAME, CLK, RST, A, C)
`define CKCL_ASSERT_NEXT(NAME, CLK, RST, A, C)

`endif

`endif

>>> src/ckcl_pkg.sv
`timescale 1ns / 1ps

package ckcl_pkg;

   localparam int NUM_BANDS_DEF  = 18;
   localparam int MAX_FRAMES_DEF = 16;
   localparam int DAY_LENGTH_DEF = 86400;

   localparam int KIND_W   = 2;
   localparam int BAND_W   = 5;
   localparam int TIME_W   = 17;
   localparam int COLOR_W  = 24;
   localparam int CHAN_W   = 8;
   localparam int CHANNELS = COLOR_W / CHAN_W;
   localparam int FRAC_W   = 16;
   localparam int DAY_W    = TIME_W + 1;
   localparam int SPAN_W   = TIME_W + 2;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BAND_W-1:0]  band;
      logic [TIME_W-1:0]  time_of_day;
      logic [COLOR_W-1:0] key_color;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               band_empty;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]  stamp;
      logic [COLOR_W-1:0] color;
   } frame_type;

   typedef struct packed {
      logic                     start;
      logic signed [SPAN_W-1:0] delta;
      logic signed [SPAN_W-1:0] span;
      logic [COLOR_W-1:0]       color_begin;
      logic [COLOR_W-1:0]       color_end;
   } mix_cmd_type;

endpackage

>>> src/ckcl_stream_if.sv
`timescale 1ns / 1ps

interface ckcl_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> src/ckcl_frame_store.sv
`timescale 1ns / 1ps

module ckcl_frame_store #(
   parameter int NUM_BANDS  = ckcl_pkg::NUM_BANDS_DEF,
   parameter int MAX_FRAMES = ckcl_pkg::MAX_FRAMES_DEF,
   parameter int BIDX_W     = 5,
   parameter int FRAME_W    = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [BIDX_W-1:0]    wr_band,
   input  logic [FRAME_W-1:0]   wr_slot,
   input  ckcl_pkg::frame_type  wr_frame,
   input  logic [BIDX_W-1:0]    rd_band,
   input  logic [FRAME_W-1:0]   rd_slot,
   output ckcl_pkg::frame_type  rd_frame
);
   import ckcl_pkg::*;

   localparam int DEPTH  = NUM_BANDS * MAX_FRAMES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   frame_type          mem [DEPTH];
   frame_type          rd_frame_ff;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   assign wr_addr = ADDR_W'(int'(wr_band) * MAX_FRAMES + int'(wr_slot));
   assign rd_addr = ADDR_W'(int'(rd_band) * MAX_FRAMES + int'(rd_slot));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_frame;
      end
      rd_frame_ff <= mem[rd_addr];
   end

   assign rd_frame = rd_frame_ff;

endmodule

>>> src/ckcl_lerp_mixer.sv
`timescale 1ns / 1ps

module ckcl_lerp_mixer (
   input  logic                         clock,
   input  logic                         reset,
   input  ckcl_pkg::mix_cmd_type        mix_cmd,
   output logic                         mix_done,
   output logic [ckcl_pkg::COLOR_W-1:0] mix_color
);
   import ckcl_pkg::*;

   localparam int REM_W = SPAN_W + 1;
   localparam int ACC_W = CHAN_W + 1 + FRAC_W;
   localparam int CNT_W = $clog2(FRAC_W + 1);
   localparam int DIF_W = CHAN_W + 1;

   localparam logic [1:0] MODE_DIV  = 2'd0;
   localparam logic [1:0] MODE_ZERO = 2'd1;
   localparam logic [1:0] MODE_SAT  = 2'd2;

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_W - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [1:0]               mode_ff, mode_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [SPAN_W-1:0]        span_ff, span_in;
   logic [COLOR_W-1:0]       base_ff, base_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic signed [DIF_W-1:0]  diff_ff [CHANNELS];
   logic signed [DIF_W-1:0]  diff_in [CHANNELS];
   logic signed [ACC_W-1:0]  acc_ff [CHANNELS];
   logic signed [ACC_W-1:0]  acc_in [CHANNELS];

   logic [REM_W-1:0]         rem_shift;
   logic                     rem_ge;
   logic                     qbit;
   logic signed [ACC_W-1:0]  rounded [CHANNELS];

   assign rem_shift = {rem_ff[REM_W-2:0], 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, span_ff});

   always_comb begin
      case (mode_ff)
         MODE_DIV:  qbit = rem_ge;
         MODE_SAT:  qbit = 1'b1;
         default:   qbit = 1'b0;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      rem_in   = rem_ff;
      span_in  = span_ff;
      base_in  = base_ff;
      color_in = color_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         diff_in[c] = diff_ff[c];
         acc_in[c]  = acc_ff[c];
         rounded[c] = acc_ff[c] + HALF;
      end

      if (mix_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         if (mix_cmd.span <= 0 || mix_cmd.delta <= 0) begin
            mode_in = MODE_ZERO;
         end else if (mix_cmd.delta >= mix_cmd.span) begin
            mode_in = MODE_SAT;
         end else begin
            mode_in = MODE_DIV;
         end
         rem_in  = REM_W'($unsigned(mix_cmd.delta));
         span_in = $unsigned(mix_cmd.span);
         base_in = mix_cmd.color_begin;
         for (int c = 0; c < CHANNELS; c++) begin
            diff_in[c] = $signed({1'b0, mix_cmd.color_end[c*CHAN_W +: CHAN_W]})
                       - $signed({1'b0, mix_cmd.color_begin[c*CHAN_W +: CHAN_W]});
            acc_in[c]  = '0;
         end
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(FRAC_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               color_in[c*CHAN_W +: CHAN_W] = base_ff[c*CHAN_W +: CHAN_W]
                                            + rounded[c][FRAC_W +: CHAN_W];
            end
         end else begin
            cnt_in = cnt_ff + 1'b1;
            rem_in = rem_ge ? (rem_shift - REM_W'(span_ff)) : rem_shift;
            for (int c = 0; c < CHANNELS; c++) begin
               acc_in[c] = (acc_ff[c] <<< 1) + (qbit ? ACC_W'(diff_ff[c]) : '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      rem_ff   <= rem_in;
      span_ff  <= span_in;
      base_ff  <= base_in;
      color_ff <= color_in;
      for (int c = 0; c < CHANNELS; c++) begin
         diff_ff[c] <= diff_in[c];
         acc_ff[c]  <= acc_in[c];
      end
   end

   assign mix_done  = done_ff;
   assign mix_color = color_ff;

endmodule

>>> src/cyclic_keyframe_color_lerp_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Payload
// req_if  | in  | valid/ready          | kind, band, time_of_day, key_color
// rsp_if  | out | valid/ready          | color, band_empty
// Clear, append and unknown kinds give no item.
// A query on an empty or missing band goes straight to its result; otherwise the core reads
// the first keyframe, scans the keyframes from the last one down, then runs a 16-step
// bit-serial divide fused with the channel multiply.
// Synchronous active-high reset empties all bands; no memory clearing pass.
// A finished item waits in the result register; a query stalls at its end while it is full.

module cyclic_keyframe_color_lerp_core #(
   parameter int NUM_BANDS  = ckcl_pkg::NUM_BANDS_DEF,
   parameter int MAX_FRAMES = ckcl_pkg::MAX_FRAMES_DEF,
   parameter int DAY_LENGTH = ckcl_pkg::DAY_LENGTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ckcl_stream_if.sink   req_if,
   ckcl_stream_if.source rsp_if
);
   import ckcl_pkg::*;
   `include "assert_macros.svh"

   localparam int BIDX_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int COUNT_W = $clog2(MAX_FRAMES + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD0  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_MIX    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam logic [DAY_W-1:0] DAY_C = DAY_W'(DAY_LENGTH);

   req_type              req;
   logic                 accept;
   logic                 band_ok;
   logic [BIDX_W-1:0]    band_idx;
   logic [COUNT_W-1:0]   count_rd;
   logic                 is_full;
   logic                 out_free;

   logic [COUNT_W-1:0]   count_ff [NUM_BANDS];
   logic [COUNT_W-1:0]   count_in [NUM_BANDS];

   logic [2:0]           state_ff, state_in;
   logic [BIDX_W-1:0]    band_ff, band_in;
   logic [TIME_W-1:0]    qtime_ff, qtime_in;
   logic [FRAME_W-1:0]   last_ff, last_in;
   logic [FRAME_W-1:0]   scan_ff, scan_in;
   logic [FRAME_W-1:0]   didx_ff, didx_in;
   logic                 first_ff, first_in;
   frame_type            head_ff, head_in;
   frame_type            prev_ff, prev_in;
   logic                 empty_ff, empty_in;
   mix_cmd_type          mix_cmd_ff, mix_cmd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 wr_en;
   frame_type            wr_frame;
   logic [FRAME_W-1:0]   rd_slot;
   frame_type            rd_frame;
   logic                 mix_done;
   logic [COLOR_W-1:0]   mix_color;

   logic                 is_last;
   logic                 hit;
   logic                 before_first;
   logic [DAY_W-1:0]     te_wrap;
   logic [DAY_W-1:0]     tq_sel;
   logic [DAY_W-1:0]     tb_sel;
   logic [DAY_W-1:0]     te_sel;

   logic                 query_take;
   logic                 query_next;
   logic                 scan_busy;
   logic                 scan_bounded;

   assign req      = req_if.payload;
   assign accept   = req_if.valid && req_if.ready;
   assign band_ok  = (int'(req.band) < NUM_BANDS);
   assign band_idx = req.band[BIDX_W-1:0];
   assign count_rd = count_ff[band_idx];
   assign is_full  = (int'(count_rd) >= MAX_FRAMES);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // band keyframe counts
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         count_in[b] = count_ff[b];
      end
      if (accept && band_ok) begin
         if (req.kind == KIND_CLEAR) begin
            count_in[band_idx] = '0;
         end else if (req.kind == KIND_APPEND && !is_full) begin
            count_in[band_idx] = count_rd + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            count_ff[b] <= '0;
         end
      end else begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            count_ff[b] <= count_in[b];
         end
      end
   end

   assign wr_en          = accept && band_ok && (req.kind == KIND_APPEND) && !is_full;
   assign wr_frame.stamp = req.time_of_day;
   assign wr_frame.color = req.key_color;
   assign rd_slot        = (state_ff == S_LOAD0) ? '0 : scan_ff;

   ckcl_frame_store #(
      .NUM_BANDS  (NUM_BANDS),
      .MAX_FRAMES (MAX_FRAMES),
      .BIDX_W     (BIDX_W),
      .FRAME_W    (FRAME_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_band  (band_idx),
      .wr_slot  (count_rd[FRAME_W-1:0]),
      .wr_frame (wr_frame),
      .rd_band  (band_ff),
      .rd_slot  (rd_slot),
      .rd_frame (rd_frame)
   );

   ckcl_lerp_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .mix_cmd   (mix_cmd_ff),
      .mix_done  (mix_done),
      .mix_color (mix_color)
   );

   // scan datapath
   assign is_last      = (didx_ff == last_ff);
   assign hit          = (rd_frame.stamp <= qtime_ff);
   assign before_first = (qtime_ff < head_ff.stamp);
   assign te_wrap      = {1'b0, head_ff.stamp} + DAY_C;

   always_comb begin
      tb_sel = {1'b0, rd_frame.stamp};
      if (before_first) begin
         tq_sel = {1'b0, qtime_ff} + DAY_C;
         te_sel = te_wrap;
      end else begin
         tq_sel = {1'b0, qtime_ff};
         te_sel = is_last ? te_wrap : {1'b0, prev_ff.stamp};
      end
   end

   always_comb begin
      state_in     = state_ff;
      band_in      = band_ff;
      qtime_in     = qtime_ff;
      last_in      = last_ff;
      scan_in      = scan_ff;
      didx_in      = didx_ff;
      first_in     = first_ff;
      head_in      = head_ff;
      prev_in      = prev_ff;
      empty_in     = empty_ff;
      mix_cmd_in   = mix_cmd_ff;
      mix_cmd_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req.kind == KIND_QUERY) begin
               if (!band_ok || count_rd == '0) begin
                  empty_in = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  empty_in = 1'b0;
                  band_in  = band_idx;
                  qtime_in = req.time_of_day;
                  last_in  = FRAME_W'(count_rd - 1'b1);
                  state_in = S_LOAD0;
               end
            end
         end
         S_LOAD0: begin
            scan_in  = last_ff;
            first_in = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (first_ff) begin
               head_in  = rd_frame;
               first_in = 1'b0;
               didx_in  = scan_ff;
               scan_in  = (scan_ff == '0) ? scan_ff : scan_ff - 1'b1;
            end else if (before_first || hit || didx_ff == '0) begin
               mix_cmd_in.start       = 1'b1;
               mix_cmd_in.delta       = $signed(SPAN_W'(tq_sel) - SPAN_W'(tb_sel));
               mix_cmd_in.span        = $signed(SPAN_W'(te_sel) - SPAN_W'(tb_sel));
               mix_cmd_in.color_begin = rd_frame.color;
               mix_cmd_in.color_end   = (before_first || is_last) ? head_ff.color
                                                                  : prev_ff.color;
               state_in               = S_MIX;
            end else begin
               prev_in = rd_frame;
               didx_in = scan_ff;
               scan_in = (scan_ff == '0) ? scan_ff : scan_ff - 1'b1;
            end
         end
         S_MIX: begin
            if (mix_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.color      = empty_ff ? '0 : mix_color;
               rsp_in.band_empty = empty_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b0;
         mix_cmd_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         mix_cmd_ff   <= mix_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      band_ff  <= band_in;
      qtime_ff <= qtime_in;
      last_ff  <= last_in;
      scan_ff  <= scan_in;
      didx_ff  <= didx_in;
      head_ff  <= head_in;
      prev_ff  <= prev_in;
      empty_ff <= empty_in;
      rsp_ff   <= rsp_in;
   end

   assign query_take   = accept && req.kind == KIND_QUERY;
   assign query_next   = state_ff == S_LOAD0 || state_ff == S_FINISH;
   assign scan_busy    = state_ff == S_SCAN && !first_ff;
   assign scan_bounded = didx_ff <= last_ff && scan_ff <= last_ff;

   `CKCL_ASSERT_NEXT(a_query_start, clock, reset, query_take, query_next)
   `CKCL_ASSERT_IMP(a_scan_bound, clock, reset, scan_busy, scan_bounded)
   `CKCL_ASSERT_IMP(a_mix_window, clock, reset, mix_done, state_ff == S_MIX)
   `CKCL_ASSERT_IMP(a_count_cap, clock, reset, accept && band_ok, int'(count_rd) <= MAX_FRAMES)

endmodule
